### hdl/eds_pkg.sv
// ----------------------------------------------------------------------------
// eds_pkg
// Shared types, constants and lookup functions for the emitter-differential
// sensor scan.
// ----------------------------------------------------------------------------
package eds_pkg;

    // field widths
    localparam int SAMPLE_W    = 12;   // width of the sample field on the bus
    localparam int CH_W        = 4;
    localparam int SENSOR_W    = 3;
    localparam int STEP_W      = 4;
    localparam int VALUE_W     = 13;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 32;

    // default converter resolution
    localparam int SAMPLE_BITS_DEF = 12;

    // scan geometry
    localparam int NUM_SENSORS = 7;
    localparam logic [STEP_W-1:0] SCAN_STEPS       = 4'd14;
    localparam logic [STEP_W-1:0] FIRST_PASS_STEPS = 4'd7;
    localparam logic [STEP_W-1:0] STEP_LAST        = 4'd13;
    localparam logic [STEP_W-1:0] STEP_EVEN_OFF    = 4'd3;
    localparam logic [STEP_W-1:0] STEP_ODD_OFF     = 4'd6;
    localparam logic [STEP_W-1:0] STEP_EVEN_ON     = 4'd10;

    // sensor whose channel comes from the config register
    localparam logic [SENSOR_W-1:0] SENSOR_LAST = 3'd6;
    localparam logic [CH_W-1:0]     LAST_CH_RST = 4'd9;

    // item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_CONV  = 1'b1;

    // per-beat result flags and channel from the step unit
    typedef struct packed {
        logic [CH_W-1:0]     next_channel;
        logic                odd_drive;
        logic                even_drive;
        logic                settle_wait;
        logic                sample_request;
        logic                busy_res;
        logic                result_valid;
        logic [SENSOR_W-1:0] sensor_index;
    } t_step_res;

    // control from the step unit to the reading store
    typedef struct packed {
        logic                wr_en;
        logic [SENSOR_W-1:0] sensor;
    } t_store_ctl;

    // sensor visited at each scan step: 0,2,4,6,1,3,5 twice
    function automatic logic [SENSOR_W-1:0] step_sensor(input logic [STEP_W-1:0] step);
        logic [SENSOR_W-1:0] s;
        unique case (step)
            4'd0, 4'd7:  s = 3'd0;
            4'd1, 4'd8:  s = 3'd2;
            4'd2, 4'd9:  s = 3'd4;
            4'd3, 4'd10: s = 3'd6;
            4'd4, 4'd11: s = 3'd1;
            4'd5, 4'd12: s = 3'd3;
            4'd6, 4'd13: s = 3'd5;
            default:     s = 3'd0;
        endcase
        return s;
    endfunction

    // analog channel of a sensor
    function automatic logic [CH_W-1:0] channel_of(input logic [SENSOR_W-1:0] sensor,
                                                   input logic [CH_W-1:0]     last_ch);
        logic [CH_W-1:0] ch;
        ch = (sensor == SENSOR_LAST) ? last_ch : CH_W'(sensor);
        return ch;
    endfunction

endpackage

### hdl/eds_store.sv
// ----------------------------------------------------------------------------
// eds_store
// First-pass readings, one per sensor, and the on-minus-off difference
// against the current sample.
// ----------------------------------------------------------------------------
module eds_store #(
    parameter int SAMPLE_BITS = eds_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  eds_pkg::t_store_ctl           i_ctl,
    input  logic [SAMPLE_BITS-1:0]        i_sample,
    output logic [eds_pkg::VALUE_W-1:0]   o_value
);
    import eds_pkg::*;

    localparam int DIFF_W = (SAMPLE_BITS > VALUE_W) ? SAMPLE_BITS : VALUE_W;

    logic [SAMPLE_BITS-1:0] r_mem [NUM_SENSORS];
    logic [DIFF_W-1:0]      diff;

    // store a first-pass reading
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.sensor] <= i_sample;
        end
    end

    // stored reading minus current reading, kept modulo the field width
    always_comb begin
        diff    = DIFF_W'(r_mem[i_ctl.sensor]) - DIFF_W'(i_sample);
        o_value = diff[VALUE_W-1:0];
    end

endmodule

### hdl/eds_step.sv
// ----------------------------------------------------------------------------
// eds_step
// Scan sequencer: step counter, scan-active flag and emitter levels, with the
// per-beat flags and next channel.
// ----------------------------------------------------------------------------
module eds_step (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  logic                       i_kind,
    input  logic [eds_pkg::CH_W-1:0]   i_last_ch,
    output eds_pkg::t_step_res         o_res,
    output eds_pkg::t_store_ctl        o_store
);
    import eds_pkg::*;

    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_active, n_active;
    logic                r_odd, n_odd;
    logic                r_even, n_even;
    logic [SENSOR_W-1:0] sensor;

    assign sensor = step_sensor(r_step);

    // next state and beat flags
    always_comb begin
        n_step   = r_step;
        n_active = r_active;
        n_odd    = r_odd;
        n_even   = r_even;
        o_res    = '0;
        o_store  = '0;
        o_store.sensor = sensor;

        if (i_fire) begin
            if (i_kind == KIND_START) begin
                n_step   = '0;
                n_active = 1'b1;
                n_odd    = 1'b1;
                o_res.settle_wait    = 1'b1;
                o_res.sample_request = 1'b1;
                o_res.next_channel   = channel_of(step_sensor('0), i_last_ch);
            end else if (r_active) begin
                if (r_step >= SCAN_STEPS) begin
                    // out-of-range step: close the scan quietly
                    n_active = 1'b0;
                    n_step   = '0;
                end else begin
                    if (r_step < FIRST_PASS_STEPS) begin
                        o_store.wr_en = 1'b1;
                    end else begin
                        o_res.result_valid = 1'b1;
                        o_res.sensor_index = sensor;
                    end
                    // emitter switching points
                    if (r_step == STEP_EVEN_OFF) begin
                        n_even = 1'b0;
                        o_res.settle_wait = 1'b1;
                    end
                    if (r_step == STEP_ODD_OFF) begin
                        n_odd = 1'b0;
                        o_res.settle_wait = 1'b1;
                    end
                    if (r_step == STEP_EVEN_ON) begin
                        n_even = 1'b1;
                        o_res.settle_wait = 1'b1;
                    end
                    if (r_step == STEP_LAST) begin
                        n_active = 1'b0;
                        n_step   = '0;
                    end else begin
                        o_res.sample_request = 1'b1;
                        o_res.next_channel   = channel_of(step_sensor(r_step + 4'd1),
                                                          i_last_ch);
                        n_step = r_step + 4'd1;
                    end
                end
            end
        end

        o_res.odd_drive  = n_odd;
        o_res.even_drive = n_even;
        o_res.busy_res   = n_active;
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= '0;
            r_active <= 1'b0;
            r_odd    <= 1'b0;
            r_even   <= 1'b1;
        end else begin
            r_step   <= n_step;
            r_active <= n_active;
            r_odd    <= n_odd;
            r_even   <= n_even;
        end
    end

endmodule

### hdl/emitter_differential_sensor_scan.sv
// ----------------------------------------------------------------------------
// emitter_differential_sensor_scan
// Path: an accepted beat goes into the input register, then into the result
// register, which drives m_axis; a stalled result beat holds the input beat back.
// Throughput: one beat per cycle unless m_axis stalls; two registers in series.
// The scan state advances once per processed beat; one result beat per input beat.
// Reset (i_rst_n low, synchronous): idle, step 0, odd emitters off, even on,
// last sensor channel 9, both stream stages empty. Stored readings not cleared.
// ----------------------------------------------------------------------------
module emitter_differential_sensor_scan #(
    parameter int SAMPLE_BITS = eds_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration: last sensor channel
    input  logic                              i_cfg_we,
    input  logic [eds_pkg::CH_W-1:0]          i_cfg_wdata,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [eds_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [11:0] sample, rest zero
    input  logic                              s_axis_tuser,  // [0] kind
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [3:0] next_channel, [4] odd emitter level, [5] even emitter level,
    // [6] settle_wait, [7] sample_request, [8] busy_res, [11:9] sensor_index,
    // [24:12] sensor_value, [31:25] zero
    output logic [eds_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tuser   // [0] result_valid
);
    import eds_pkg::*;

    localparam int IN_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;

    logic [CH_W-1:0]        r_last_channel;
    logic                   r_in_valid;
    logic                   r_in_kind;
    logic [SAMPLE_W-1:0]    r_in_sample;
    logic                   r_out_valid;
    logic [OUT_DATA_W-1:0]  r_out_data;
    logic                   r_out_user;
    logic                   fire;
    logic [SAMPLE_BITS-1:0] smp;
    t_step_res              res;
    t_store_ctl             store_ctl;
    logic [VALUE_W-1:0]     diff;
    logic [VALUE_W-1:0]     value;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_channel <= LAST_CH_RST;
        end else begin
            if (i_cfg_we) begin
                r_last_channel <= i_cfg_wdata;
            end
        end
    end

    // handshake
    assign fire          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_kind   <= s_axis_tuser;
            r_in_sample <= s_axis_tdata[SAMPLE_W-1:0];
        end
    end

    // sample masked to the converter resolution
    assign smp = SAMPLE_BITS'(r_in_sample[IN_BITS-1:0]);

    eds_step u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_kind    (r_in_kind),
        .i_last_ch (r_last_channel),
        .o_res     (res),
        .o_store   (store_ctl)
    );

    eds_store #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_store (
        .i_clk    (i_clk),
        .i_ctl    (store_ctl),
        .i_sample (smp),
        .o_value  (diff)
    );

    assign value = res.result_valid ? diff : '0;

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= {7'd0, value, res.sensor_index, res.busy_res,
                           res.sample_request, res.settle_wait, res.even_drive,
                           res.odd_drive, res.next_channel};
            r_out_user <= res.result_valid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

### hdl/eds_check.sv
// ----------------------------------------------------------------------------
// eds_check
// Port-level checks on the result stream of the sensor scan.
// ----------------------------------------------------------------------------
module eds_check (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [eds_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                              m_axis_tuser
);
    import eds_pkg::*;

    // a request is issued exactly while the scan continues
    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7] == m_axis_tdata[8]))
        else $error("sample_request and busy_res disagree");

    // no request means channel zero
    a_ch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[7]) |-> (m_axis_tdata[3:0] == 4'd0))
        else $error("channel given without a sample request");

    // no difference means zero index and value
    a_res_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[24:9] == 16'd0))
        else $error("sensor fields set without a finished difference");

    // a finished difference names a real sensor
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[11:9] != 3'd7))
        else $error("sensor index out of range");

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result beat changed");

endmodule

bind emitter_differential_sensor_scan eds_check u_eds_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### bench/eds_scan_checker.sv
// ----------------------------------------------------------------------------
// eds_scan_checker
// Watches the configuration port and both stream channels of the sensor scan,
// predicts one result beat per accepted input beat and compares it field by
// field with the beats the block delivers, oldest expectation first.
// ----------------------------------------------------------------------------
module eds_scan_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [eds_pkg::CH_W-1:0]       i_cfg_wdata,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [eds_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // [11:0] sample, rest zero
    input  logic                           s_axis_tuser,   // [0] kind
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [3:0] next_channel, [4] odd emitter level, [5] even emitter level,
    // [6] settle_wait, [7] sample_request, [8] busy_res, [11:9] sensor_index,
    // [24:12] sensor_value, [31:25] zero
    input  logic [eds_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                           m_axis_tuser,   // [0] result_valid
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_diff_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import eds_pkg::*;

    localparam int REPORT_MAX = 10;

    // sensor visited in each half of the scan, entry 0 in the low bits
    localparam logic [3*NUM_SENSORS-1:0] SENSOR_ORDER =
        {3'd5, 3'd3, 3'd1, 3'd6, 3'd4, 3'd2, 3'd0};

    typedef struct packed {
        logic [6:0]                pad;
        logic [CH_W-1:0]           next_channel;
        logic                      odd_drive;
        logic                      even_drive;
        logic                      settle_wait;
        logic                      sample_request;
        logic                      busy;
        logic                      result_valid;
        logic [SENSOR_W-1:0]       sensor_index;
        logic signed [VALUE_W-1:0] sensor_value;
    } t_scan_beat;

    // predicted scan state
    logic [STEP_W-1:0]   step_q    = '0;
    logic                active_q  = 1'b0;
    logic                odd_on_q  = 1'b0;
    logic                even_on_q = 1'b1;
    logic [CH_W-1:0]     last_ch_q = LAST_CH_RST;
    logic [SAMPLE_W-1:0] first_rd [NUM_SENSORS];

    t_scan_beat beats_due[$];

    function automatic logic [SENSOR_W-1:0] sensor_at(input logic [STEP_W-1:0] step);
        int slot;
        slot = int'(step) % NUM_SENSORS;
        return SENSOR_ORDER[3*slot +: 3];
    endfunction

    function automatic logic [CH_W-1:0] channel_at(input logic [STEP_W-1:0] step);
        logic [SENSOR_W-1:0] sns;
        sns = sensor_at(step);
        return (sns == SENSOR_LAST) ? last_ch_q : CH_W'(sns);
    endfunction

    // advance the predicted scan by one input beat and build its result
    function automatic t_scan_beat scan_step(input logic kind,
                                             input logic [SAMPLE_W-1:0] smp);
        t_scan_beat          b;
        logic [SENSOR_W-1:0] sns;
        b = '0;
        if (kind == KIND_START) begin
            step_q           = '0;
            active_q         = 1'b1;
            odd_on_q         = 1'b1;
            b.settle_wait    = 1'b1;
            b.sample_request = 1'b1;
            b.next_channel   = channel_at('0);
        end else if (active_q) begin
            if (step_q >= SCAN_STEPS) begin
                // out-of-range step: just end the scan
                active_q = 1'b0;
                step_q   = '0;
            end else begin
                sns = sensor_at(step_q);
                if (step_q < FIRST_PASS_STEPS) begin
                    first_rd[sns] = smp;
                end else begin
                    b.result_valid = 1'b1;
                    b.sensor_index = sns;
                    b.sensor_value = VALUE_W'({1'b0, first_rd[sns]} - {1'b0, smp});
                end
                if (step_q == STEP_EVEN_OFF) begin
                    even_on_q     = 1'b0;
                    b.settle_wait = 1'b1;
                end
                if (step_q == STEP_ODD_OFF) begin
                    odd_on_q      = 1'b0;
                    b.settle_wait = 1'b1;
                end
                if (step_q == STEP_EVEN_ON) begin
                    even_on_q     = 1'b1;
                    b.settle_wait = 1'b1;
                end
                if (step_q == STEP_LAST) begin
                    active_q = 1'b0;
                    step_q   = '0;
                end else begin
                    b.sample_request = 1'b1;
                    b.next_channel   = channel_at(step_q + 1'b1);
                    step_q           = step_q + 1'b1;
                end
            end
        end
        // idle conversions fall through: only the emitter levels show
        b.odd_drive  = odd_on_q;
        b.even_drive = even_on_q;
        b.busy       = active_q;
        return b;
    endfunction

    function automatic string fmt_beat(input t_scan_beat b);
        return $sformatf({"ch=%0d odd=%0b even=%0b settle=%0b req=%0b busy=%0b ",
                          "vld=%0b idx=%0d val=%0d pad=%0h"},
                         b.next_channel, b.odd_drive, b.even_drive, b.settle_wait,
                         b.sample_request, b.busy, b.result_valid, b.sensor_index,
                         $signed(b.sensor_value), b.pad);
    endfunction

    // everything sampled mid-cycle: inputs only move at the rising edge
    always @(negedge i_clk) begin
        t_scan_beat seen;
        t_scan_beat want;
        if (!i_rst_n) begin
            step_q    = '0;
            active_q  = 1'b0;
            odd_on_q  = 1'b0;
            even_on_q = 1'b1;
            last_ch_q = LAST_CH_RST;
            beats_due.delete();
        end else begin
            if (i_cfg_we)
                last_ch_q = i_cfg_wdata;

            if (s_axis_tvalid && s_axis_tready)
                beats_due.push_back(scan_step(s_axis_tuser, s_axis_tdata[SAMPLE_W-1:0]));

            if (m_axis_tvalid && m_axis_tready) begin
                seen.pad            = m_axis_tdata[31:25];
                seen.next_channel   = m_axis_tdata[3:0];
                seen.odd_drive      = m_axis_tdata[4];
                seen.even_drive     = m_axis_tdata[5];
                seen.settle_wait    = m_axis_tdata[6];
                seen.sample_request = m_axis_tdata[7];
                seen.busy           = m_axis_tdata[8];
                seen.sensor_index   = m_axis_tdata[11:9];
                seen.sensor_value   = m_axis_tdata[24:12];
                seen.result_valid   = m_axis_tuser;
                if (beats_due.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_MAX)
                        $display("[%0t] unexpected result beat: %s", $time, fmt_beat(seen));
                end else begin
                    want = beats_due.pop_front();
                    if (want.result_valid)
                        o_diff_count++;
                    if (seen !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= REPORT_MAX) begin
                            $display("[%0t] result beat mismatch", $time);
                            $display("    expected %s", fmt_beat(want));
                            $display("    actual   %s", fmt_beat(seen));
                        end
                    end
                end
            end
        end
        o_pending = beats_due.size();
    end

endmodule

### bench/emitter_differential_sensor_scan_tb.sv
// ----------------------------------------------------------------------------
// emitter_differential_sensor_scan_tb
// Drives the sensor scan with a directed opening (extreme readings, idle
// conversions, restart mid-scan) and then random full and broken scans under
// several idle/stall mixes and last-channel settings; the checker compares
// every result beat.
// ----------------------------------------------------------------------------
module emitter_differential_sensor_scan_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import eds_pkg::*;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int HOLD_CYCLES     = 300;
    localparam int STALL_LIMIT     = 4000;
    localparam int DRAIN_CYCLES    = 4;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CH_W-1:0]       cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    int   idle_pct     = 0;
    int   stall_pct    = 0;
    logic hold_req     = 1'b0;
    logic hold_started = 1'b0;
    int   hold_left    = 0;

    int fail_count;
    int pending;
    int diff_count;
    int beats_sent    = 0;
    int scans_started = 0;
    int scan_items    = 0;

    always #5 clk = ~clk;

    emitter_differential_sensor_scan DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    eds_scan_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_diff_count  (diff_count)
    );

    // result side: random stalls, plus one long hold-off on request
    always @(posedge clk) begin
        if (hold_req && !hold_started) begin
            hold_started <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            m_tready     <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog: cycles without any beat or register write
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(negedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        logic [SAMPLE_W-1:0] v;
        case ($urandom_range(7))
            0:       v = '0;
            1:       v = '1;
            default: v = SAMPLE_W'($urandom_range(4095));
        endcase
        return v;
    endfunction

    // offer one beat, with an optional idle gap first; returns at the
    // rising edge that accepted it
    task automatic send_beat(input logic kind, input logic [SAMPLE_W-1:0] smp);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'(smp);
        s_tuser  <= kind;
        do
            @(negedge clk);
        while (!s_tready);
        @(posedge clk);
        beats_sent++;
        if (kind == KIND_START)
            scans_started++;
    endtask

    // start beat followed by a number of conversions
    task automatic run_scan(input int n_conv);
        send_beat(KIND_START, rand_sample());
        repeat (n_conv)
            send_beat(KIND_CONV, rand_sample());
        scan_items += n_conv + 1;
    endtask

    // wait until every predicted beat has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_last_channel(input logic [CH_W-1:0] ch);
        cfg_we    <= 1'b1;
        cfg_wdata <= ch;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_random(input int n_items);
        int goal;
        int pick;
        int n_stray;
        goal = scan_items + n_items;
        while (scan_items < goal) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                run_scan(STEP_LAST + 1);
            end else if (pick < 88) begin
                run_scan($urandom_range(1, 12));
            end else if (pick < 95) begin
                // stray conversions, often while idle
                n_stray = $urandom_range(1, 3);
                repeat (n_stray)
                    send_beat(KIND_CONV, rand_sample());
                scan_items += n_stray;
            end else begin
                run_scan(0);
            end
        end
    endtask

    // stimulus
    initial begin
        logic [CH_W-1:0] ch;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle conversion, then a full scan with extreme readings
        send_beat(KIND_CONV, 12'hFFF);
        send_beat(KIND_START, 12'hABC);
        send_beat(KIND_CONV, 12'hFFF);
        send_beat(KIND_CONV, 12'h000);
        send_beat(KIND_CONV, 12'hAAA);
        send_beat(KIND_CONV, 12'h555);
        send_beat(KIND_CONV, 12'h001);
        send_beat(KIND_CONV, 12'h800);
        send_beat(KIND_CONV, 12'h7FF);
        send_beat(KIND_CONV, 12'h000);
        send_beat(KIND_CONV, 12'hFFF);
        send_beat(KIND_CONV, 12'h555);
        send_beat(KIND_CONV, 12'hAAA);
        send_beat(KIND_CONV, 12'h000);
        send_beat(KIND_CONV, 12'h7FF);
        send_beat(KIND_CONV, 12'h800);
        // after the end of scan, and a restart in the middle of a scan
        send_beat(KIND_CONV, 12'h123);
        send_beat(KIND_START, 12'h000);
        send_beat(KIND_CONV, 12'h321);
        send_beat(KIND_CONV, 12'hFED);
        send_beat(KIND_START, 12'hFFF);
        send_beat(KIND_CONV, 12'h0F0);
        drain();

        // random phases under different last-channel settings and idling
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       ch = '1;
                1:       ch = '0;
                2:       ch = LAST_CH_RST;
                default: ch = CH_W'($urandom_range(15));
            endcase
            write_last_channel(ch);
            case (p % 4)
                0: begin
                    idle_pct = 0;
                    stall_pct <= 0;
                end
                1: begin
                    idle_pct = 82;
                    stall_pct <= 0;
                end
                2: begin
                    idle_pct = 0;
                    stall_pct <= 82;
                end
                default: begin
                    idle_pct = 9;
                    stall_pct <= 9;
                end
            endcase
            // first phase: hold the result side off to back up the input
            if (p == 0)
                hold_req <= 1'b1;
            run_random(ITEMS_PER_PHASE);
            drain();
        end

        repeat (10) @(posedge clk);
        $display("Run: %0d input beats, %0d scan starts, %0d sensor differences checked,",
                 beats_sent, scans_started, diff_count);
        $display("     %0d last-channel settings, idle/stall mixes and one long output hold-off.",
                 PHASES);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### files.f
hdl/eds_pkg.sv
hdl/eds_store.sv
hdl/eds_step.sv
hdl/emitter_differential_sensor_scan.sv
hdl/eds_check.sv
bench/eds_scan_checker.sv
bench/emitter_differential_sensor_scan_tb.sv
